### rtl/core/m68alu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m68alu_pkg
// Shared types, codes and helper functions of the integer ALU, shifter and
// condition-code block.
// ----------------------------------------------------------------------------
package m68alu_pkg;

	typedef enum logic [3:0] {
		OP_TEST = 4'd0,
		OP_ADD  = 4'd1,
		OP_ADDX = 4'd2,
		OP_SUB  = 4'd3,
		OP_SUBX = 4'd4,
		OP_CMP  = 4'd5,
		OP_EOR  = 4'd6,
		OP_ASL  = 4'd7,
		OP_ASR  = 4'd8,
		OP_LSL  = 4'd9,
		OP_LSR  = 4'd10,
		OP_ROXL = 4'd11,
		OP_ROXR = 4'd12,
		OP_ROL  = 4'd13,
		OP_ROR  = 4'd14,
		OP_NOP  = 4'd15
	} op_t;

	typedef enum logic [1:0] {
		SZ_BYTE = 2'd0,
		SZ_WORD = 2'd1,
		SZ_LONG = 2'd2,
		SZ_LONG_ALT = 2'd3
	} size_t;

	typedef enum logic [3:0] {
		CC_T  = 4'd0,
		CC_F  = 4'd1,
		CC_HI = 4'd2,
		CC_LS = 4'd3,
		CC_CC = 4'd4,
		CC_CS = 4'd5,
		CC_NE = 4'd6,
		CC_EQ = 4'd7,
		CC_VC = 4'd8,
		CC_VS = 4'd9,
		CC_PL = 4'd10,
		CC_MI = 4'd11,
		CC_GE = 4'd12,
		CC_LT = 4'd13,
		CC_GT = 4'd14,
		CC_LE = 4'd15
	} cc_t;

	localparam int unsigned IN_BYTES  = 10;
	localparam int unsigned OUT_BYTES = 5;
	localparam logic [31:0] MASK_BYTE = 32'h0000_00FF;
	localparam logic [31:0] MASK_WORD = 32'h0000_FFFF;
	localparam logic [31:0] MASK_LONG = 32'hFFFF_FFFF;

	typedef struct packed {
		logic x;
		logic n;
		logic z;
		logic v;
		logic c;
	} ccr_t;

	typedef struct packed {
		cc_t         cond_code;
		logic [5:0]  shift_count;
		logic [31:0] dst_operand;
		logic [31:0] src_operand;
		size_t       size_code;
		op_t         alu_op;
	} item_t;

	typedef struct packed {
		logic        cond_true;
		ccr_t        flags_out;
		logic [31:0] result;
	} res_t;

	function automatic logic cond_holds(input ccr_t f, input cc_t cc);
		logic h;
		case (cc)
			CC_T:    h = 1'b1;
			CC_F:    h = 1'b0;
			CC_HI:   h = !f.c && !f.z;
			CC_LS:   h = f.c || f.z;
			CC_CC:   h = !f.c;
			CC_CS:   h = f.c;
			CC_NE:   h = !f.z;
			CC_EQ:   h = f.z;
			CC_VC:   h = !f.v;
			CC_VS:   h = f.v;
			CC_PL:   h = !f.n;
			CC_MI:   h = f.n;
			CC_GE:   h = (f.n == f.v);
			CC_LT:   h = (f.n != f.v);
			CC_GT:   h = !f.z && (f.n == f.v);
			default: h = f.z || (f.n != f.v);
		endcase
		return h;
	endfunction

	// count modulo a ring width of 9, 17 or 33
	function automatic logic [5:0] mod_ring(input logic [5:0] n, input logic [5:0] w);
		logic [8:0] mult;
		logic [5:0] r;
		r = n;
		for (int i = 1; i < 8; i++) begin
			mult = 9'(i) * {3'd0, w};
			if ({3'd0, n} >= mult) begin
				r = n - mult[5:0];
			end
		end
		return r;
	endfunction

endpackage

### rtl/core/m68alu_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m68alu_exec
// Single-pass datapath: adder, barrel shifter, rotator, flag and condition
// logic for one item against the current condition codes.
// ----------------------------------------------------------------------------
module m68alu_exec (
	input  m68alu_pkg::item_t item,
	input  m68alu_pkg::ccr_t  ccr,
	output m68alu_pkg::res_t  res
);

	logic [5:0]  bits;
	logic [31:0] m;
	logic [31:0] topmask;
	logic [31:0] s;
	logic [31:0] dd;
	logic        cin;
	logic        is_sub;
	logic [32:0] sum;
	logic        c_ar;
	logic        v_ar;
	logic [31:0] r_ar;
	logic [63:0] shl;
	logic [32:0] shr;
	logic        sign;
	logic [64:0] sx;
	logic [64:0] sa;
	logic [6:0]  cnt_p1;
	logic [31:0] wmask;
	logic [31:0] sw;
	logic        v_asl;
	logic [32:0] ring;
	logic [5:0]  w_rx;
	logic [5:0]  k_rx;
	logic [5:0]  k_ro;
	logic [5:0]  rot_w;
	logic [5:0]  rot_amt;
	logic [32:0] rot_val;
	logic [65:0] rot_tmp;
	logic [65:0] rot_hi;
	logic [32:0] rot_wm;
	logic [32:0] rot;
	logic [31:0] r;
	logic        c;
	logic        v;
	m68alu_pkg::ccr_t nf;
	logic [31:0] full;

	always_comb begin
		case (item.size_code)
			m68alu_pkg::SZ_BYTE: begin
				bits = 6'd8;
				m    = m68alu_pkg::MASK_BYTE;
			end
			m68alu_pkg::SZ_WORD: begin
				bits = 6'd16;
				m    = m68alu_pkg::MASK_WORD;
			end
			default: begin
				bits = 6'd32;
				m    = m68alu_pkg::MASK_LONG;
			end
		endcase
	end

	assign topmask = m ^ (m >> 1);
	assign s       = item.src_operand & m;
	assign dd      = item.dst_operand & m;

	// add / subtract
	assign cin    = (item.alu_op == m68alu_pkg::OP_ADDX || item.alu_op == m68alu_pkg::OP_SUBX)
		? ccr.x : 1'b0;
	assign is_sub = (item.alu_op == m68alu_pkg::OP_SUB || item.alu_op == m68alu_pkg::OP_SUBX
		|| item.alu_op == m68alu_pkg::OP_CMP);
	assign sum    = is_sub ? ({1'b0, dd} - {1'b0, s} - {32'd0, cin})
		: ({1'b0, dd} + {1'b0, s} + {32'd0, cin});
	assign r_ar   = sum[31:0] & m;
	assign c_ar   = sum[bits];
	assign v_ar   = is_sub ? (|((dd ^ s) & (dd ^ r_ar) & topmask))
		: (|((dd ^ r_ar) & (s ^ r_ar) & topmask));

	// shifts
	assign shl    = {32'd0, s} << item.shift_count;
	assign shr    = {s, 1'b0} >> item.shift_count;
	assign sign   = |(s & topmask);
	assign sx     = {{32{sign}}, s | (sign ? ~m : 32'd0), 1'b0};
	assign sa     = 65'($signed(sx) >>> item.shift_count);
	assign cnt_p1 = {1'b0, item.shift_count} + 7'd1;
	assign wmask  = m & ~(m >> cnt_p1);
	assign sw     = s & wmask;
	assign v_asl  = (item.shift_count < bits) ? ((sw != 32'd0) && (sw != wmask))
		: (s != 32'd0);

	// rotates share one rotate-left unit
	assign ring = ({32'd0, ccr.x} << bits) | {1'b0, s};
	assign w_rx = bits + 6'd1;
	assign k_rx = m68alu_pkg::mod_ring(item.shift_count, w_rx);
	assign k_ro = item.shift_count & (bits - 6'd1);

	always_comb begin
		case (item.alu_op)
			m68alu_pkg::OP_ROXL: begin
				rot_val = ring;
				rot_w   = w_rx;
				rot_amt = k_rx;
			end
			m68alu_pkg::OP_ROXR: begin
				rot_val = ring;
				rot_w   = w_rx;
				rot_amt = (k_rx == 6'd0) ? 6'd0 : (w_rx - k_rx);
			end
			m68alu_pkg::OP_ROR: begin
				rot_val = {1'b0, s};
				rot_w   = bits;
				rot_amt = (k_ro == 6'd0) ? 6'd0 : (bits - k_ro);
			end
			default: begin
				rot_val = {1'b0, s};
				rot_w   = bits;
				rot_amt = k_ro;
			end
		endcase
	end

	assign rot_tmp = {33'd0, rot_val} << rot_amt;
	assign rot_hi  = rot_tmp >> rot_w;
	assign rot_wm  = (33'd1 << rot_w) - 33'd1;
	assign rot     = (rot_tmp[32:0] & rot_wm) | rot_hi[32:0];

	always_comb begin
		r = 32'd0;
		c = 1'b0;
		v = 1'b0;
		case (item.alu_op)
			m68alu_pkg::OP_TEST: r = s;
			m68alu_pkg::OP_EOR:  r = dd ^ s;
			m68alu_pkg::OP_ADD, m68alu_pkg::OP_ADDX, m68alu_pkg::OP_SUB,
			m68alu_pkg::OP_SUBX, m68alu_pkg::OP_CMP: begin
				r = r_ar;
				c = c_ar;
				v = v_ar;
			end
			m68alu_pkg::OP_ASL, m68alu_pkg::OP_LSL: begin
				r = shl[31:0] & m;
				c = shl[bits];
				v = (item.alu_op == m68alu_pkg::OP_ASL) && (item.shift_count != 6'd0) && v_asl;
			end
			m68alu_pkg::OP_ASR: begin
				r = sa[32:1] & m;
				c = sa[0];
			end
			m68alu_pkg::OP_LSR: begin
				r = shr[32:1];
				c = shr[0];
			end
			m68alu_pkg::OP_ROXL, m68alu_pkg::OP_ROXR: begin
				r = rot[31:0] & m;
				c = rot[bits];
			end
			m68alu_pkg::OP_ROL: begin
				r = rot[31:0] & m;
				c = (item.shift_count != 6'd0) && rot[0];
			end
			m68alu_pkg::OP_ROR: begin
				r = rot[31:0] & m;
				c = (item.shift_count != 6'd0) && (|(rot[31:0] & topmask));
			end
			default: r = dd;
		endcase
	end

	always_comb begin
		nf   = ccr;
		full = (item.dst_operand & ~m) | r;
		case (item.alu_op)
			m68alu_pkg::OP_TEST, m68alu_pkg::OP_EOR: begin
				nf.c = 1'b0;
				nf.v = 1'b0;
				nf.n = |(r & topmask);
				nf.z = (r == 32'd0);
			end
			m68alu_pkg::OP_ADD, m68alu_pkg::OP_SUB, m68alu_pkg::OP_CMP: begin
				nf.x = (item.alu_op == m68alu_pkg::OP_CMP) ? ccr.x : c;
				nf.c = c;
				nf.v = v;
				nf.n = |(r & topmask);
				nf.z = (r == 32'd0);
				if (item.alu_op == m68alu_pkg::OP_CMP) begin
					full = item.dst_operand;
				end
			end
			m68alu_pkg::OP_ADDX, m68alu_pkg::OP_SUBX: begin
				nf.x = c;
				nf.c = c;
				nf.v = v;
				nf.n = |(r & topmask);
				nf.z = (r == 32'd0) && ccr.z;
			end
			m68alu_pkg::OP_NOP: full = item.dst_operand;
			default: begin
				if (item.alu_op == m68alu_pkg::OP_ROXL || item.alu_op == m68alu_pkg::OP_ROXR) begin
					nf.x = c;
				end else if (item.alu_op == m68alu_pkg::OP_ROL || item.alu_op == m68alu_pkg::OP_ROR
					|| item.shift_count == 6'd0) begin
					nf.x = ccr.x;
				end else begin
					nf.x = c;
				end
				nf.c = c;
				nf.v = v;
				nf.n = |(r & topmask);
				nf.z = (r == 32'd0);
			end
		endcase
	end

	assign res.result    = full;
	assign res.flags_out = nf;
	assign res.cond_true = m68alu_pkg::cond_holds(ccr, item.cond_code);

endmodule

### rtl/core/m68k_alu_shifter_with_flags_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m68k_alu_shifter_with_flags_core
// Integer ALU and shifter with X N Z V C condition-code register.
//
//   channel  | dir | tdata fields (low bit up)
//   s_axis   | in  | alu_op, size_code, src_operand, dst_operand, shift_count,
//            |     | cond_code
//   m_axis   | out | result, flags_out, cond_true
//
// Input register, then result register; one beat per cycle unless stalled.
// The condition-code register updates as an item moves from the input
// register to the result register, so the next item sees its flags.
// Reset clears the flags and both valid bits.
// A stalled result holds the input register; input stays ready while the
// result register drains.
// ----------------------------------------------------------------------------
module m68k_alu_shifter_with_flags_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// alu_op[3:0], size_code[5:4], src_operand[37:6], dst_operand[69:38],
	// shift_count[75:70], cond_code[79:76]
	input  logic [8*m68alu_pkg::IN_BYTES-1:0]  s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// result[31:0], flags_out[36:32], cond_true[37], zero pad [39:38]
	output logic [8*m68alu_pkg::OUT_BYTES-1:0] m_axis_tdata
);

	logic               valid_s1;
	logic               valid_s2;
	m68alu_pkg::item_t  item_s1;
	m68alu_pkg::res_t   res_s2;
	m68alu_pkg::res_t   res_next;
	m68alu_pkg::ccr_t   ccr_q;
	logic               advance;
	logic               in_beat;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	m68alu_exec u_exec (
		.item (item_s1),
		.ccr  (ccr_q),
		.res  (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			ccr_q    <= '0;
		end else begin
			if (in_beat) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				ccr_q    <= res_next.flags_out;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			item_s1 <= m68alu_pkg::item_t'(s_axis_tdata[79:0]);
		end
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {2'b00, res_s2};

endmodule

### rtl/core/m68alu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m68alu_checker
// Port-level checks of the ALU core: stall hold, ready while the output
// drains, no result beat without an input beat, and zero pad bits.
// ----------------------------------------------------------------------------
module m68alu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [8*m68alu_pkg::IN_BYTES-1:0]  s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [8*m68alu_pkg::OUT_BYTES-1:0] m_axis_tdata
);

	logic in_beat;

	assign in_beat = s_axis_tvalid && s_axis_tready;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
		else $error("input not ready while output drains");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_beat ##1 (!in_beat && !m_axis_tvalid)) |=> !m_axis_tvalid)
		else $error("result beat without input beat");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[39:38] == 2'b00))
		else $error("pad bits of result beat not zero");

endmodule

bind m68k_alu_shifter_with_flags_core m68alu_checker u_m68alu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
